### design/nlbp_pkg.sv
// Shared types and constants of the NIC load-balance planner.
`default_nettype none
package nlbp_pkg;

  localparam int unsigned FieldW     = 36;
  localparam int unsigned MaxResults = 25;
  localparam int unsigned ResCntW    = 5;
  localparam int unsigned HomeMul    = 17;
  localparam int unsigned FarMul     = 31;

  typedef enum logic [1:0] {
    CFG_LANE_COUNT     = 2'd0,
    CFG_HOME_SERVER    = 2'd1,
    CFG_OWN_LINK_FIRST = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] demand;
    logic [7:0]  far_server;
    logic [31:0] round_number;
    logic        tile_end;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        from_gpu;
    logic [1:0]        via_link;
    logic [1:0]        to_gpu;
    logic [FieldW-1:0] amount;
    logic [FieldW-1:0] tile_sum;
    logic [FieldW-1:0] staged_records;
    logic [FieldW-1:0] offdiag_before;
    logic [FieldW-1:0] final_repair;
    logic [FieldW-1:0] direct_records;
    logic [1:0]        rotation_start;
    logic              run_end;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUM_INIT,
    OP_SCAN_RD,
    OP_SUM_ACC,
    OP_ROT_GO,
    OP_ROT_TAKE,
    OP_TOT_TAKE,
    OP_TARGET,
    OP_ROW,
    OP_ROW_NEXT,
    OP_NIC_NEXT,
    OP_NIC_TAKE,
    OP_K_READ,
    OP_K_SKIP,
    OP_K_SUB,
    OP_K_ADD,
    OP_ERR,
    OP_REP_INIT,
    OP_REP_ACC,
    OP_FINAL
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic row_in;
    logic rs_zero;
    logic nic_in;
    logic def_zero;
    logic k_in;
    logic rd_zero;
    logic m_zero;
    logic full;
    logic scan_last;
    logic out_free;
  } stat_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_SUM_INIT,
    S_SUM_RD,
    S_SUM_ACC,
    S_ROT,
    S_ROT_WAIT,
    S_TOT_WAIT,
    S_TARGET,
    S_ROW,
    S_WHILE,
    S_SCAN_NIC,
    S_KLOOP,
    S_KREAD,
    S_KADD,
    S_REP_INIT,
    S_REP_RD,
    S_REP_ACC,
    S_FINAL
  } state_e;

endpackage
`default_nettype wire

### design/nlbp_div.sv
// Restoring divider by a small divisor, one quotient bit per cycle.
`default_nettype none
module nlbp_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned GW = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [GW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o,
  output logic [GW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] acc_q, acc_d;
  logic [GW-1:0] rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [GW:0]   sh;
  logic          qbit;

  // one shift-and-subtract step
  always_comb begin
    sh     = {rem_q, acc_q[DW-1]};
    qbit   = (sh >= {1'b0, dvs_q});
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = qbit ? GW'(sh - {1'b0, dvs_q}) : GW'(sh);
      acc_d = {acc_q[DW-2:0], qbit};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= GW'(1);
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      if (start_i) dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### design/nlbp_ctrl.sv
// Planner sequencer: loads a tile, then steps sums, divisions, targets, moves, repair sum and summary.
`default_nettype none
module nlbp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_tile_end_i,
  output logic                 in_ready_o,
  input  wire nlbp_pkg::stat_t st_i,
  output nlbp_pkg::cmd_t       cmd_o
);

  nlbp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlbp_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = nlbp_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      nlbp_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = nlbp_pkg::OP_LOAD;
          if (in_tile_end_i) state_d = nlbp_pkg::S_SUM_INIT;
        end
      end
      nlbp_pkg::S_SUM_INIT: begin
        cmd_o.op = nlbp_pkg::OP_SUM_INIT;
        state_d  = nlbp_pkg::S_SUM_RD;
      end
      nlbp_pkg::S_SUM_RD: begin
        cmd_o.op = nlbp_pkg::OP_SCAN_RD;
        state_d  = nlbp_pkg::S_SUM_ACC;
      end
      nlbp_pkg::S_SUM_ACC: begin
        cmd_o.op = nlbp_pkg::OP_SUM_ACC;
        state_d  = st_i.scan_last ? nlbp_pkg::S_ROT : nlbp_pkg::S_SUM_RD;
      end
      nlbp_pkg::S_ROT: begin
        cmd_o.op = nlbp_pkg::OP_ROT_GO;
        state_d  = nlbp_pkg::S_ROT_WAIT;
      end
      nlbp_pkg::S_ROT_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.op = nlbp_pkg::OP_ROT_TAKE;
          state_d  = nlbp_pkg::S_TOT_WAIT;
        end
      end
      nlbp_pkg::S_TOT_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.op = nlbp_pkg::OP_TOT_TAKE;
          state_d  = nlbp_pkg::S_TARGET;
        end
      end
      nlbp_pkg::S_TARGET: begin
        cmd_o.op = nlbp_pkg::OP_TARGET;
        state_d  = nlbp_pkg::S_ROW;
      end
      nlbp_pkg::S_ROW: begin
        if (st_i.row_in) begin
          cmd_o.op = nlbp_pkg::OP_ROW;
          state_d  = nlbp_pkg::S_WHILE;
        end else begin
          state_d = nlbp_pkg::S_REP_INIT;
        end
      end
      nlbp_pkg::S_WHILE: begin
        if (st_i.rs_zero) begin
          cmd_o.op = nlbp_pkg::OP_ROW_NEXT;
          state_d  = nlbp_pkg::S_ROW;
        end else begin
          state_d = nlbp_pkg::S_SCAN_NIC;
        end
      end
      // find the lowest link with a deficit
      nlbp_pkg::S_SCAN_NIC: begin
        if (!st_i.nic_in) begin
          cmd_o.op = nlbp_pkg::OP_ERR;
          state_d  = nlbp_pkg::S_REP_INIT;
        end else if (st_i.def_zero) begin
          cmd_o.op = nlbp_pkg::OP_NIC_NEXT;
        end else begin
          cmd_o.op = nlbp_pkg::OP_NIC_TAKE;
          state_d  = nlbp_pkg::S_KLOOP;
        end
      end
      nlbp_pkg::S_KLOOP: begin
        if (st_i.k_in && !st_i.rs_zero && !st_i.rd_zero) begin
          cmd_o.op = nlbp_pkg::OP_K_READ;
          state_d  = nlbp_pkg::S_KREAD;
        end else if (!st_i.rs_zero && !st_i.rd_zero) begin
          cmd_o.op = nlbp_pkg::OP_ERR;
          state_d  = nlbp_pkg::S_REP_INIT;
        end else begin
          state_d = nlbp_pkg::S_WHILE;
        end
      end
      nlbp_pkg::S_KREAD: begin
        if (st_i.m_zero) begin
          cmd_o.op = nlbp_pkg::OP_K_SKIP;
          state_d  = nlbp_pkg::S_KLOOP;
        end else if (st_i.full) begin
          cmd_o.op = nlbp_pkg::OP_ERR;
          state_d  = nlbp_pkg::S_REP_INIT;
        end else begin
          cmd_o.op = nlbp_pkg::OP_K_SUB;
          state_d  = nlbp_pkg::S_KADD;
        end
      end
      nlbp_pkg::S_KADD: begin
        if (st_i.out_free) begin
          cmd_o.op = nlbp_pkg::OP_K_ADD;
          state_d  = nlbp_pkg::S_KLOOP;
        end
      end
      nlbp_pkg::S_REP_INIT: begin
        cmd_o.op = nlbp_pkg::OP_REP_INIT;
        state_d  = nlbp_pkg::S_REP_RD;
      end
      nlbp_pkg::S_REP_RD: begin
        cmd_o.op = nlbp_pkg::OP_SCAN_RD;
        state_d  = nlbp_pkg::S_REP_ACC;
      end
      nlbp_pkg::S_REP_ACC: begin
        cmd_o.op = nlbp_pkg::OP_REP_ACC;
        state_d  = st_i.scan_last ? nlbp_pkg::S_FINAL : nlbp_pkg::S_REP_RD;
      end
      nlbp_pkg::S_FINAL: begin
        if (st_i.out_free) begin
          cmd_o.op = nlbp_pkg::OP_FINAL;
          state_d  = nlbp_pkg::S_LOAD;
        end
      end
      default: state_d = nlbp_pkg::S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

### design/nlbp_dp.sv
// Planner datapath: tile memory, sums, divider, targets, moves, result register.
`default_nettype none
module nlbp_dp #(
  parameter int unsigned MAX_LANES   = 4,
  parameter int unsigned DEMAND_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire nlbp_pkg::in_t   in_data_i,
  input  wire nlbp_pkg::cmd_t  cmd_i,
  output nlbp_pkg::stat_t      st_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output nlbp_pkg::out_t       out_data_o
);

  localparam int unsigned LW    = $clog2(MAX_LANES);
  localparam int unsigned GW    = LW + 1;
  localparam int unsigned PW    = 2 * LW + 1;
  localparam int unsigned AW    = 2 * LW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned SW    = DEMAND_BITS + 2 * LW;
  localparam int unsigned DW    = (SW > 32) ? SW : 32;
  localparam logic [31:0] DMask =
    (DEMAND_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DEMAND_BITS) - 64'd1);

  // configuration registers
  logic [2:0] lane_q;
  logic [7:0] home_q;
  logic       own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= 3'd4;
      home_q <= '0;
      own_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nlbp_pkg::CFG_LANE_COUNT:     lane_q <= cfg_data_i[2:0];
        nlbp_pkg::CFG_HOME_SERVER:    home_q <= cfg_data_i;
        nlbp_pkg::CFG_OWN_LINK_FIRST: own_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective lane count
  logic [GW-1:0] g;
  logic [LW-1:0] gm1;
  always_comb begin
    if (lane_q == 3'd0) g = GW'(1);
    else if (int'(lane_q) > MAX_LANES) g = GW'(MAX_LANES);
    else g = GW'(lane_q);
  end
  assign gm1 = LW'(g - GW'(1));

  // state
  logic [PW-1:0]       pos_q;
  logic [7:0]          server_q;
  logic [31:0]         round_q;
  logic [SW-1:0]       row_q [MAX_LANES];
  logic [SW-1:0]       sur_q [MAX_LANES];
  logic [SW-1:0]       def_q [MAX_LANES];
  logic [SW-1:0]       total_q, static_q, repair_q, staged_q, direct_q;
  logic [SW-1:0]       base_q, rs_q, rd_q, m_q;
  logic [GW-1:0]       remv_q, r_q, nic_q, k_q;
  logic [LW-1:0]       first_q, scan_r_q, scan_c_q;
  logic [nlbp_pkg::ResCntW-1:0] n_q;
  logic                err_q;
  logic                out_valid_q, out_valid_d;
  nlbp_pkg::out_t      out_q, out_d;
  logic [SW-1:0]       m_val;

  // tile memory with per-entry valid bits
  logic [SW-1:0]    mem [Depth];
  logic [Depth-1:0] vld_q, vld_d;
  logic [SW-1:0]    rdata_q, rdat;
  logic             rvld_q;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [SW-1:0]    wdata;

  // entry placement by the lane count at arrival
  logic [PW-1:0] gg, acc, lc_full;
  logic [LW-1:0] lr, lc;
  logic          in_tile;
  always_comb begin
    gg  = PW'(g) * PW'(g);
    lr  = '0;
    acc = PW'(g);
    for (int q = 1; q < MAX_LANES; q++) begin
      if (acc <= pos_q) lr = lr + LW'(1);
      acc = acc + PW'(g);
    end
    lc_full = pos_q - PW'(lr) * PW'(g);
    lc      = lc_full[LW-1:0];
    in_tile = (pos_q < gg);
  end

  // link index for step k
  logic [GW-1:0] dk;
  logic [LW-1:0] d;
  always_comb begin
    if (own_q) begin
      if (k_q == '0) dk = nic_q;
      else begin
        dk = k_q - GW'(1);
        if (dk >= nic_q) dk = dk + GW'(1);
      end
    end else begin
      dk = k_q;
    end
    d = dk[LW-1:0];
  end

  // memory port control
  assign rdat = rvld_q ? rdata_q : '0;
  always_comb begin
    we    = 1'b0;
    waddr = {lr, lc};
    wdata = SW'(in_data_i.demand & DMask);
    re    = 1'b0;
    raddr = {scan_r_q, scan_c_q};
    case (cmd_i.op)
      nlbp_pkg::OP_LOAD: we = in_tile;
      nlbp_pkg::OP_SCAN_RD: re = 1'b1;
      nlbp_pkg::OP_K_READ: begin
        re    = 1'b1;
        raddr = {r_q[LW-1:0], d};
      end
      nlbp_pkg::OP_K_SUB: begin
        we    = 1'b1;
        waddr = {r_q[LW-1:0], d};
        wdata = rdat - m_val;
        re    = 1'b1;
        raddr = {nic_q[LW-1:0], d};
      end
      nlbp_pkg::OP_K_ADD: begin
        we    = 1'b1;
        waddr = {nic_q[LW-1:0], d};
        wdata = rdat + m_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // valid bits: cleared at the first entry of a tile, set on every write
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.op == nlbp_pkg::OP_LOAD && pos_q == '0) vld_d = '0;
    if (we) vld_d[waddr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (re) rvld_q <= vld_q[raddr];
    end
  end

  // move size: least of surplus, deficit and the entry
  always_comb begin
    m_val = (rs_q < rd_q) ? rs_q : rd_q;
    if (rdat < m_val) m_val = rdat;
  end

  // rotation start and shared divider
  logic [31:0]   rot;
  logic          div_go, div_done;
  logic [DW-1:0] div_in, quot;
  logic [GW-1:0] div_rem;
  assign rot = 32'(home_q) * 32'(nlbp_pkg::HomeMul)
             + 32'(server_q) * 32'(nlbp_pkg::FarMul) + round_q;
  assign div_go = (cmd_i.op == nlbp_pkg::OP_ROT_GO) || (cmd_i.op == nlbp_pkg::OP_ROT_TAKE);
  assign div_in = (cmd_i.op == nlbp_pkg::OP_ROT_GO) ? DW'(rot) : DW'(total_q);

  nlbp_div #(.DW(DW), .GW(GW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_in),
    .divisor_i  (g),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (div_rem)
  );

  // per-link targets, surplus and deficit
  logic [SW-1:0] sur_n [MAX_LANES];
  logic [SW-1:0] def_n [MAX_LANES];
  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      logic [GW:0]   rel;
      logic [SW-1:0] tgt;
      rel = (GW+1)'(i) + (GW+1)'(g) - (GW+1)'(first_q);
      if (rel >= (GW+1)'(g)) rel = rel - (GW+1)'(g);
      tgt = base_q + SW'(rel < (GW+1)'(remv_q));
      sur_n[i] = '0;
      def_n[i] = '0;
      if (GW'(i) < g) begin
        if (row_q[i] > tgt) sur_n[i] = row_q[i] - tgt;
        else def_n[i] = tgt - row_q[i];
      end
    end
  end

  logic scan_last;
  assign scan_last = (scan_r_q == gm1) && (scan_c_q == gm1);

  // sequenced state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      server_q    <= '0;
      round_q     <= '0;
      total_q     <= '0;
      static_q    <= '0;
      repair_q    <= '0;
      staged_q    <= '0;
      direct_q    <= '0;
      base_q      <= '0;
      rs_q        <= '0;
      rd_q        <= '0;
      m_q         <= '0;
      remv_q      <= '0;
      r_q         <= '0;
      nic_q       <= '0;
      k_q         <= '0;
      first_q     <= '0;
      scan_r_q    <= '0;
      scan_c_q    <= '0;
      n_q         <= '0;
      err_q       <= 1'b0;
      for (int i = 0; i < MAX_LANES; i++) begin
        row_q[i] <= '0;
        sur_q[i] <= '0;
        def_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        nlbp_pkg::OP_LOAD: begin
          if (pos_q == '0) begin
            server_q <= in_data_i.far_server;
            round_q  <= in_data_i.round_number;
          end
          if (in_data_i.tile_end) pos_q <= '0;
          else if (in_tile) pos_q <= pos_q + PW'(1);
        end
        nlbp_pkg::OP_SUM_INIT: begin
          total_q  <= '0;
          static_q <= '0;
          scan_r_q <= '0;
          scan_c_q <= '0;
          for (int i = 0; i < MAX_LANES; i++) row_q[i] <= '0;
        end
        nlbp_pkg::OP_SUM_ACC: begin
          row_q[scan_r_q] <= row_q[scan_r_q] + rdat;
          total_q         <= total_q + rdat;
          if (scan_r_q != scan_c_q) static_q <= static_q + rdat;
          if (scan_c_q == gm1) begin
            scan_c_q <= '0;
            scan_r_q <= scan_r_q + LW'(1);
          end else begin
            scan_c_q <= scan_c_q + LW'(1);
          end
        end
        nlbp_pkg::OP_ROT_TAKE: first_q <= div_rem[LW-1:0];
        nlbp_pkg::OP_TOT_TAKE: begin
          base_q <= SW'(quot);
          remv_q <= div_rem;
        end
        nlbp_pkg::OP_TARGET: begin
          for (int i = 0; i < MAX_LANES; i++) begin
            sur_q[i] <= sur_n[i];
            def_q[i] <= def_n[i];
          end
          r_q      <= '0;
          nic_q    <= '0;
          staged_q <= '0;
          direct_q <= '0;
          n_q      <= '0;
          err_q    <= 1'b0;
        end
        nlbp_pkg::OP_ROW:      rs_q  <= sur_q[r_q[LW-1:0]];
        nlbp_pkg::OP_ROW_NEXT: r_q   <= r_q + GW'(1);
        nlbp_pkg::OP_NIC_NEXT: nic_q <= nic_q + GW'(1);
        nlbp_pkg::OP_NIC_TAKE: begin
          rd_q <= def_q[nic_q[LW-1:0]];
          k_q  <= '0;
        end
        nlbp_pkg::OP_K_SKIP: k_q <= k_q + GW'(1);
        nlbp_pkg::OP_K_SUB:  m_q <= m_val;
        nlbp_pkg::OP_K_ADD: begin
          rs_q                <= rs_q - m_q;
          rd_q                <= rd_q - m_q;
          def_q[nic_q[LW-1:0]] <= def_q[nic_q[LW-1:0]] - m_q;
          staged_q            <= staged_q + m_q;
          if (dk == nic_q) direct_q <= direct_q + m_q;
          k_q                 <= k_q + GW'(1);
          n_q                 <= n_q + nlbp_pkg::ResCntW'(1);
        end
        nlbp_pkg::OP_ERR: err_q <= 1'b1;
        nlbp_pkg::OP_REP_INIT: begin
          repair_q <= '0;
          scan_r_q <= '0;
          scan_c_q <= '0;
        end
        nlbp_pkg::OP_REP_ACC: begin
          if (scan_r_q != scan_c_q) repair_q <= repair_q + rdat;
          if (scan_c_q == gm1) begin
            scan_c_q <= '0;
            scan_r_q <= scan_r_q + LW'(1);
          end else begin
            scan_c_q <= scan_c_q + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register: a move or the summary loads it, the sink drains it
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (cmd_i.op)
      nlbp_pkg::OP_K_ADD: begin
        out_valid_d     = 1'b1;
        out_d           = '0;
        out_d.kind      = nlbp_pkg::KIND_MOVE;
        out_d.from_gpu  = 2'(r_q);
        out_d.via_link  = 2'(nic_q);
        out_d.to_gpu    = 2'(d);
        out_d.amount    = nlbp_pkg::FieldW'(m_q);
      end
      nlbp_pkg::OP_FINAL: begin
        out_valid_d          = 1'b1;
        out_d                = '0;
        out_d.kind           = err_q ? nlbp_pkg::KIND_ERROR : nlbp_pkg::KIND_SUMMARY;
        out_d.tile_sum       = nlbp_pkg::FieldW'(total_q);
        out_d.staged_records = nlbp_pkg::FieldW'(staged_q);
        out_d.offdiag_before = nlbp_pkg::FieldW'(static_q);
        out_d.final_repair   = nlbp_pkg::FieldW'(repair_q);
        out_d.direct_records = nlbp_pkg::FieldW'(direct_q);
        out_d.rotation_start = 2'(first_q);
        out_d.run_end        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // status to the sequencer
  always_comb begin
    st_o.div_done  = div_done;
    st_o.row_in    = (r_q < g);
    st_o.rs_zero   = (rs_q == '0);
    st_o.nic_in    = (nic_q < g);
    st_o.def_zero  = (def_q[nic_q[LW-1:0]] == '0);
    st_o.k_in      = (k_q < g);
    st_o.rd_zero   = (rd_q == '0);
    st_o.m_zero    = (m_val == '0);
    st_o.full      = (int'(n_q) >= nlbp_pkg::MaxResults - 1);
    st_o.scan_last = scan_last;
    st_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == nlbp_pkg::OP_K_ADD || cmd_i.op == nlbp_pkg::OP_FINAL)
      |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transaction");

  // a move is nonzero and leaves room for the final result
  a_move_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == nlbp_pkg::OP_K_SUB)
      |-> (m_val != '0 && int'(n_q) < nlbp_pkg::MaxResults - 1))
    else $error("bad move size or result budget exceeded");

  // committed move never exceeds surplus or deficit
  a_move_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == nlbp_pkg::OP_K_ADD) |-> (m_q <= rs_q && m_q <= rd_q))
    else $error("move larger than surplus or deficit");
`endif

endmodule
`default_nettype wire

### design/nic_load_balance_planner_top.sv
// Top level of the NIC load-balance planner.
`default_nettype none
// Takes one demand entry per cycle until tile_end. Planning then runs: a
// pass over the tile entries to sum rows and total, two restoring divisions
// by the lane count of a max(DEMAND_BITS+2*log2(MAX_LANES), 32)-bit dividend
// (rotation start, then target), the targets, then the greedy walk over the
// candidate entries and links, a second pass over the entries for the final
// off-diagonal sum, and the summary transaction. A move or summary waits in
// the output register when the sink stalls; the next tile is taken only
// after the summary is loaded.
module nic_load_balance_planner_top #(
  parameter int unsigned MAX_LANES   = 4,
  parameter int unsigned DEMAND_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [7:0]     cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire nlbp_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output nlbp_pkg::out_t      out_data_o
);

  nlbp_pkg::cmd_t  cmd;
  nlbp_pkg::stat_t st;

  nlbp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_tile_end_i (in_data_i.tile_end),
    .in_ready_o    (in_ready_o),
    .st_i          (st),
    .cmd_o         (cmd)
  );

  nlbp_dp #(
    .MAX_LANES   (MAX_LANES),
    .DEMAND_BITS (DEMAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
